FILE: design/bfrm_pkg.sv
// Package for the byte FIFO with rewind mark.
// Holds the item types, the action codes and the per-item result struct.
// No dependencies.
package bfrm_pkg;

    localparam int CAP_W  = 11;
    localparam int BYTE_W = 8;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_POP    = 3'd1;
    localparam logic [2:0] ACT_MARK   = 3'd2;
    localparam logic [2:0] ACT_UNMARK = 3'd3;
    localparam logic [2:0] ACT_REWIND = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;
    localparam logic [2:0] ACT_STATUS = 3'd6;

    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

    typedef struct packed {
        logic [2:0]        action;
        logic [BYTE_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic              success;
        logic [BYTE_W-1:0] read_data;
        logic [CAP_W-1:0]  fill_count;
        logic              is_empty;
        logic              push_allowed;
    } t_out_item;

    // Status of one item, passed from the pointer logic to the result register.
    typedef struct packed {
        logic             success;
        logic             pop_hit;
        logic             pop_miss;
        logic [CAP_W-1:0] fill_count;
        logic             is_empty;
        logic             push_allowed;
    } t_step_res;

endpackage

FILE: design/bfrm_ifs.sv
// Handshake channels of the byte FIFO with rewind mark: input, result and
// capacity write. Depends on bfrm_pkg.
interface bfrm_in_if;
    logic               valid;
    logic               ready;
    bfrm_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfrm_out_if;
    logic                valid;
    logic                ready;
    bfrm_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfrm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bfrm_pkg::CAP_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/bfrm_mem.sv
// Byte storage of the FIFO: one write port and one registered read port.
// Depends on nothing but its parameters.
module bfrm_mem #(
    parameter int DEPTH = 1024,
    parameter int PW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [PW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [PW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_store [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_store[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bfrm_ptr.sv
// Pointer, count and mark state of the FIFO, with the next-state logic for
// one item and the capacity register. Depends on bfrm_pkg.
module bfrm_ptr #(
    parameter int DEPTH = 1024,
    parameter int PW    = 10,
    parameter int CW    = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bfrm_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                       i_accept,
    input  logic [2:0]                 i_action,
    output logic                       o_mem_we,
    output logic [PW-1:0]              o_mem_waddr,
    output logic                       o_mem_re,
    output logic [PW-1:0]              o_mem_raddr,
    output bfrm_pkg::t_step_res        o_res
);
    import bfrm_pkg::*;

    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_wp, n_wp;
    logic [CW-1:0]    r_held, n_held;
    logic             r_mark, n_mark;
    logic [PW-1:0]    r_mpos, n_mpos;

    logic [XW-1:0] cap_x;
    logic [CW-1:0] cap;
    logic [CW-1:0] rp_c, wp_c, mp_c;
    logic [CW-1:0] rp_inc, wp_inc;
    logic [CW-1:0] to_mark, to_wr, room, steps_a, steps;
    logic [CW-1:0] rp_back;
    logic [XW-1:0] held_x;
    logic          held_nz;

    // Capacity of zero behaves as one; anything above the storage depth as DEPTH.
    always_comb begin
        cap_x = XW'(r_capacity);
        if (cap_x == '0) begin
            cap = CW'(1);
        end else if (cap_x > XW'(DEPTH)) begin
            cap = CW'(DEPTH);
        end else begin
            cap = cap_x[CW-1:0];
        end
    end

    assign rp_c    = CW'(r_rp);
    assign wp_c    = CW'(r_wp);
    assign mp_c    = CW'(r_mpos);
    assign rp_inc  = rp_c + CW'(1);
    assign wp_inc  = wp_c + CW'(1);
    assign held_nz = (r_held != '0);

    // Rewind distance: the smallest of the way back to the mark, the way back
    // to the write pointer (a full lap when they coincide) and the free room.
    always_comb begin
        to_mark = (rp_c >= mp_c) ? (rp_c - mp_c) : (cap - (mp_c - rp_c));
        if (rp_c > wp_c) begin
            to_wr = rp_c - wp_c;
        end else if (rp_c == wp_c) begin
            to_wr = cap;
        end else begin
            to_wr = cap - (wp_c - rp_c);
        end
        room    = cap - r_held;
        steps_a = (to_mark < to_wr) ? to_mark : to_wr;
        steps   = (steps_a < room) ? steps_a : room;
        rp_back = (rp_c >= steps) ? (rp_c - steps) : (cap - (steps - rp_c));
    end

    always_comb begin
        n_rp   = r_rp;
        n_wp   = r_wp;
        n_held = r_held;
        n_mark = r_mark;
        n_mpos = r_mpos;
        o_res.success  = 1'b0;
        o_res.pop_hit  = 1'b0;
        o_res.pop_miss = 1'b0;
        unique case (i_action)
            ACT_PUSH: begin
                if (r_held < cap) begin
                    n_wp   = (wp_inc >= cap) ? '0 : wp_inc[PW-1:0];
                    n_held = r_held + CW'(1);
                    o_res.success = 1'b1;
                end
            end
            ACT_POP: begin
                if (held_nz) begin
                    n_rp   = (rp_inc >= cap) ? '0 : rp_inc[PW-1:0];
                    n_held = r_held - CW'(1);
                    o_res.success = 1'b1;
                    o_res.pop_hit = 1'b1;
                end else begin
                    o_res.pop_miss = 1'b1;
                end
            end
            ACT_MARK: begin
                n_mark = 1'b1;
                n_mpos = r_rp;
            end
            ACT_UNMARK: begin
                n_mark = 1'b0;
            end
            ACT_REWIND: begin
                if (r_mark) begin
                    n_rp   = rp_back[PW-1:0];
                    n_held = r_held + steps;
                end
            end
            ACT_CLEAR: begin
                n_rp   = '0;
                n_wp   = '0;
                n_held = '0;
                n_mark = 1'b0;
            end
            default: begin
            end
        endcase

        held_x             = XW'(n_held);
        o_res.fill_count   = held_x[CAP_W-1:0];
        o_res.is_empty     = (n_held == '0);
        o_res.push_allowed = !((n_held == cap) ||
                               (n_mark && (n_held != '0) && (n_wp == n_rp)));
    end

    assign o_mem_we    = i_accept && (i_action == ACT_PUSH) && (r_held < cap);
    assign o_mem_waddr = r_wp;
    assign o_mem_re    = i_accept && (i_action == ACT_POP) && held_nz;
    assign o_mem_raddr = r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(1024);
            r_rp       <= '0;
            r_wp       <= '0;
            r_held     <= '0;
            r_mark     <= 1'b0;
            r_mpos     <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
            r_rp       <= '0;
            r_wp       <= '0;
            r_held     <= '0;
            r_mark     <= 1'b0;
            r_mpos     <= '0;
        end else if (i_accept) begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_held <= n_held;
            r_mark <= n_mark;
            r_mpos <= n_mpos;
        end
    end

endmodule

FILE: design/byte_fifo_with_rewind_mark.sv
// Byte FIFO with a read mark that the read pointer can be rewound to. It takes
// one item per clock cycle and presents its result in the cycle after acceptance
// from a single output register; the input is held off only while that register
// is full and not being taken. Each item is one pass through the pointer logic
// and at most one access to the byte memory, whose registered read port
// supplies the popped byte. A capacity write clears the pointers, count and
// mark at once; no clearing pass runs after reset.
// Depends on bfrm_pkg, bfrm_ifs, bfrm_mem and bfrm_ptr.
module byte_fifo_with_rewind_mark #(
    parameter int DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfrm_in_if.sink    i_in,
    bfrm_out_if.source o_out,
    bfrm_cfg_if.sink   i_cfg
);
    import bfrm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          accept;
    logic          in_ready;
    logic          mem_we;
    logic          mem_re;
    logic [PW-1:0] mem_waddr;
    logic [PW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    t_step_res     step_res;
    t_step_res     r_res;
    logic          r_out_valid;

    assign in_ready    = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    bfrm_ptr #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_accept    (accept),
        .i_action    (i_in.data.action),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_res       (step_res)
    );

    bfrm_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in.data.write_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    // The memory read register only loads on an accepted pop, so it holds
    // the popped byte for as long as the result waits.
    always_comb begin
        o_out.valid             = r_out_valid;
        o_out.data.success      = r_res.success;
        o_out.data.fill_count   = r_res.fill_count;
        o_out.data.is_empty     = r_res.is_empty;
        o_out.data.push_allowed = r_res.push_allowed;
        if (r_res.pop_hit) begin
            o_out.data.read_data = mem_rdata;
        end else if (r_res.pop_miss) begin
            o_out.data.read_data = EMPTY_BYTE;
        end else begin
            o_out.data.read_data = '0;
        end
    end

endmodule
